>>> design/psk_symbol_mapper_upsampler_core_macros.svh
// Assertion macros shared by the checker of the PSK symbol mapper.
// Depends on signals named clk and rst_n in the module that uses them.
`ifndef PSK_SYMBOL_MAPPER_UPSAMPLER_CORE_MACROS_SVH
`define PSK_SYMBOL_MAPPER_UPSAMPLER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define PSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/psm_pkg.sv
// Shared types, constants and the CORDIC angle table of the PSK symbol mapper.
// No dependencies; every module of the design imports this package.
package psm_pkg;

  localparam int SYMBOL_W     = 16;
  localparam int LEVELS_W     = 9;
  localparam int OVS_W        = 5;
  localparam int PHASE_W      = 32;
  localparam int CW           = 32;
  localparam int CORDIC_STEPS = 16;
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 9;

  localparam int DEF_MAX_OVERSAMPLE = 16;
  localparam int DEF_SAMPLE_BITS    = 16;
  localparam int DEF_MAX_LEVELS     = 256;

  localparam logic [LEVELS_W-1:0] LEVELS_RST = LEVELS_W'(4);
  localparam logic [OVS_W-1:0]    OVS_RST    = OVS_W'(1);

  // Gain-compensated 1.0 in Q1.30.
  localparam logic signed [CW-1:0] CORDIC_X0 = 32'sd652032874;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_LEVELS     = 1'b0,
    CFG_OVERSAMPLE = 1'b1
  } cfg_reg_t;

  // One step of the long division: remainder and the quotient bits so far.
  typedef struct packed {
    logic                valid;
    logic [LEVELS_W-1:0] rem;
    logic [PHASE_W-1:0]  quot;
  } div_stage_t;

  // One step of the rotation: vector, residual angle and quadrant info.
  typedef struct packed {
    logic                 valid;
    logic                 zero;
    logic [1:0]           quad;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } rot_stage_t;

  // atan(2^-step) in units of 2^32 per turn.
  function automatic logic signed [CW-1:0] atan_turns(input int step);
    logic signed [CW-1:0] a;
    unique case (step)
      0:       a = 32'sd536870912;
      1:       a = 32'sd316933406;
      2:       a = 32'sd167458907;
      3:       a = 32'sd85004756;
      4:       a = 32'sd42667331;
      5:       a = 32'sd21354465;
      6:       a = 32'sd10680350;
      7:       a = 32'sd5340245;
      8:       a = 32'sd2670163;
      9:       a = 32'sd1335087;
      10:      a = 32'sd667544;
      11:      a = 32'sd333772;
      12:      a = 32'sd166886;
      13:      a = 32'sd83443;
      14:      a = 32'sd41722;
      15:      a = 32'sd20861;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

>>> design/psm_div_cell.sv
// One restoring-division cell: shifts in one dividend bit, produces one quotient bit.
// Depends on psm_pkg for div_stage_t.
module psm_div_cell import psm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [LEVELS_W-1:0] divisor,
  input  logic                dividend_bit,
  input  div_stage_t          d_in,
  output div_stage_t          d_out
);

  logic [LEVELS_W:0]   trial;
  logic                fits;
  logic                valid_r;
  logic [LEVELS_W-1:0] rem_r, rem_nxt;
  logic [PHASE_W-1:0]  quot_r, quot_nxt;

  always_comb begin
    trial    = {d_in.rem, dividend_bit};
    fits     = trial >= {1'b0, divisor};
    rem_nxt  = fits ? LEVELS_W'(trial - {1'b0, divisor}) : trial[LEVELS_W-1:0];
    quot_nxt = {d_in.quot[PHASE_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= d_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      quot_r <= quot_nxt;
    end
  end

  assign d_out = '{valid: valid_r, rem: rem_r, quot: quot_r};

endmodule

>>> design/psm_cordic_cell.sv
// One rotation-mode CORDIC cell with a fixed shift and angle per position in the chain.
// Depends on psm_pkg for rot_stage_t and the angle table.
module psm_cordic_cell import psm_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  rot_stage_t r_in,
  output rot_stage_t r_out
);

  localparam logic signed [CW-1:0] ATAN  = atan_turns(STEP);
  localparam logic [CW-1:0]        RMASK = (CW'(1) << STEP) - CW'(1);

  logic signed [CW-1:0] dx, dy;
  logic signed [CW-1:0] x_nxt, y_nxt, z_nxt;
  logic                 valid_r;
  logic                 zero_r;
  logic [1:0]           quad_r;
  logic signed [CW-1:0] x_r, y_r, z_r;

  // Shift with truncation toward zero. The correction term is kept signed so
  // that the shift stays arithmetic.
  always_comb begin
    dx = (r_in.y >>> STEP) + $signed(CW'(r_in.y[CW-1] && (|(r_in.y & RMASK))));
    dy = (r_in.x >>> STEP) + $signed(CW'(r_in.x[CW-1] && (|(r_in.x & RMASK))));
    if (!r_in.z[CW-1]) begin
      x_nxt = r_in.x - dx;
      y_nxt = r_in.y + dy;
      z_nxt = r_in.z - ATAN;
    end else begin
      x_nxt = r_in.x + dx;
      y_nxt = r_in.y - dy;
      z_nxt = r_in.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= r_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_r <= r_in.zero;
      quad_r <= r_in.quad;
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
    end
  end

  assign r_out = '{valid: valid_r, zero: zero_r, quad: quad_r, x: x_r, y: y_r, z: z_r};

endmodule

>>> design/psk_symbol_mapper_upsampler_core.sv
// Stages: division cells, quadrant register, CORDIC cells, rounding and output
// registers. Throughput: one symbol per cycle at oversample 1 with out_tready
// high; otherwise each sample repeats oversample times and the chain stalls while
// the rounding stage is full. The 32 division and 16 CORDIC cells each take one
// step per cycle as the chain advances. Reset (rst_n low, synchronous) empties the
// pipeline and output register and restores levels to 4 and oversample to 1.
module psk_symbol_mapper_upsampler_core import psm_pkg::*; #(
  parameter int MAX_OVERSAMPLE = DEF_MAX_OVERSAMPLE,
  parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
  parameter int MAX_LEVELS     = DEF_MAX_LEVELS,
  localparam int OUT_W         = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Configuration write port.
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  // Symbol input stream.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [SYMBOL_W-1:0]    in_tdata,   // [15:0] symbol
  // Sample output stream.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_W-1:0]       out_tdata,  // i_sample, then q_sample, zero padded
  output logic                   out_tlast   // last copy of the sample
);

  // The level count is held in a 9-bit register, so the clamp can never be
  // larger than that register can express. Same for the oversample count.
  localparam int LEV_CAP_I = (MAX_LEVELS > 511) ? 511 : MAX_LEVELS;
  localparam int OVS_CAP_I = (MAX_OVERSAMPLE > 31) ? 31 : MAX_OVERSAMPLE;
  localparam logic [LEVELS_W-1:0] LEV_CAP = LEVELS_W'(LEV_CAP_I);
  localparam logic [OVS_W-1:0]    OVS_CAP = OVS_W'(OVS_CAP_I);

  // Rounding from Q1.30 down to the output format.
  localparam int RSH = 31 - SAMPLE_BITS;
  localparam logic [CW-1:0] HALF   = CW'(1) << (RSH - 1);
  localparam logic [CW-1:0] FULL_W = (CW'(1) << (SAMPLE_BITS - 1)) - CW'(1);
  localparam logic signed [SAMPLE_BITS-1:0] FULL_S = SAMPLE_BITS'(FULL_W);

  localparam logic [PHASE_W-1:0] QUARTER_HALF = PHASE_W'(1) << (PHASE_W - 3);

  // Effective configuration, with zero and out-of-range values already fixed up
  // at write time. half_r is floor(levels / 2), the rounding term of the phase.
  logic [LEVELS_W-1:0] m_r;
  logic [LEVELS_W-2:0] half_r;
  logic [OVS_W-1:0]    n_r;
  logic [LEVELS_W-1:0] lev_raw, lev_eff;
  logic [OVS_W-1:0]    ovs_raw, ovs_eff;

  always_comb begin
    lev_raw = cfg_wdata[LEVELS_W-1:0];
    ovs_raw = cfg_wdata[OVS_W-1:0];
    if (lev_raw == '0) begin
      lev_eff = LEVELS_W'(1);
    end else if (lev_raw > LEV_CAP) begin
      lev_eff = LEV_CAP;
    end else begin
      lev_eff = lev_raw;
    end
    if (ovs_raw == '0) begin
      ovs_eff = OVS_W'(1);
    end else if (ovs_raw > OVS_CAP) begin
      ovs_eff = OVS_CAP;
    end else begin
      ovs_eff = ovs_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r    <= LEVELS_RST;
      half_r <= LEVELS_RST[LEVELS_W-1:1];
      n_r    <= OVS_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_LEVELS: begin
          m_r    <= lev_eff;
          half_r <= lev_eff[LEVELS_W-1:1];
        end
        CFG_OVERSAMPLE: begin
          n_r <= ovs_eff;
        end
      endcase
    end
  end

  // The whole chain moves together: it advances whenever the rounding stage
  // is empty or hands its sample to the output register. Bubbles in the chain
  // therefore keep absorbing symbols while the output still repeats a sample, until a sample fills the rounding stage.
  logic adv;
  logic out_load;
  logic out_valid_r;
  logic [OVS_W-1:0] cnt_r;
  logic out_last;

  assign in_tready = adv;

  // Phase = floor((s * 2^32 + floor(M/2)) / M) mod 2^32. A symbol at or above M
  // lands on a whole turn, which is the same as symbol zero. With s below M the
  // division starts from remainder s and only the low word is shifted in.
  logic [PHASE_W-1:0] half_word;
  div_stage_t div_s [0:PHASE_W];

  assign half_word = PHASE_W'(half_r);

  always_comb begin
    div_s[0].valid = in_tvalid;
    div_s[0].rem   = (in_tdata >= SYMBOL_W'(m_r)) ? '0 : in_tdata[LEVELS_W-1:0];
    div_s[0].quot  = '0;
  end

  for (genvar k = 0; k < PHASE_W; k++) begin : g_div
    psm_div_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .en           (adv),
      .divisor      (m_r),
      .dividend_bit (half_word[PHASE_W-1-k]),
      .d_in         (div_s[k]),
      .d_out        (div_s[k+1])
    );
  end

  // Quadrant folding: shift by an eighth turn, take the top two bits as the
  // quadrant and keep a residual within plus or minus an eighth turn.
  logic [PHASE_W-1:0]   shifted;
  logic                 ph_valid_r;
  logic                 ph_zero_r;
  logic [1:0]           ph_quad_r;
  logic signed [CW-1:0] ph_z_r;

  assign shifted = div_s[PHASE_W].quot + QUARTER_HALF;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_valid_r <= 1'b0;
    end else if (adv) begin
      ph_valid_r <= div_s[PHASE_W].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ph_quad_r <= shifted[PHASE_W-1:PHASE_W-2];
      ph_zero_r <= (shifted[PHASE_W-3:0] == QUARTER_HALF[PHASE_W-3:0]);
      ph_z_r    <= $signed({2'b00, shifted[PHASE_W-3:0]}) - $signed(QUARTER_HALF);
    end
  end

  // Rotation chain, one CORDIC step per cell.
  rot_stage_t rot_s [0:CORDIC_STEPS];

  assign rot_s[0] = '{valid: ph_valid_r, zero: ph_zero_r, quad: ph_quad_r,
                      x: CORDIC_X0, y: '0, z: ph_z_r};

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
    psm_cordic_cell #(.STEP(k)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .r_in  (rot_s[k]),
      .r_out (rot_s[k+1])
    );
  end

  // Round half away from zero and saturate symmetrically.
  function automatic logic signed [SAMPLE_BITS-1:0] to_sample(
    input logic signed [CW-1:0] v
  );
    logic [CW-1:0] mag;
    logic [CW-1:0] rnd;
    logic [CW-1:0] lim;
    mag = v[CW-1] ? CW'(-v) : CW'(v);
    rnd = (mag + HALF) >> RSH;
    lim = (rnd > FULL_W) ? FULL_W : rnd;
    return v[CW-1] ? -SAMPLE_BITS'(lim) : SAMPLE_BITS'(lim);
  endfunction

  rot_stage_t                      rot_end;
  logic                            rd_valid_r;
  logic [1:0]                      rd_quad_r;
  logic signed [SAMPLE_BITS-1:0]   rd_c_r, rd_s_r;

  assign rot_end = rot_s[CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else if (adv) begin
      rd_valid_r <= rot_end.valid;
    end
  end

  // A residual of exactly zero skips the rotation and gives full scale.
  always_ff @(posedge clk) begin
    if (adv) begin
      rd_quad_r <= rot_end.quad;
      rd_c_r    <= rot_end.zero ? FULL_S : to_sample(rot_end.x);
      rd_s_r    <= rot_end.zero ? '0 : to_sample(rot_end.y);
    end
  end

  // Output register: unfolds the quadrant and repeats the sample n times.
  logic signed [SAMPLE_BITS-1:0] i_nxt, q_nxt;
  logic signed [SAMPLE_BITS-1:0] i_r, q_r;

  always_comb begin
    unique case (rd_quad_r)
      2'd0: begin
        i_nxt = rd_c_r;
        q_nxt = rd_s_r;
      end
      2'd1: begin
        i_nxt = -rd_s_r;
        q_nxt = rd_c_r;
      end
      2'd2: begin
        i_nxt = -rd_c_r;
        q_nxt = -rd_s_r;
      end
      2'd3: begin
        i_nxt = rd_s_r;
        q_nxt = -rd_c_r;
      end
    endcase
  end

  assign out_last = (cnt_r == (n_r - OVS_W'(1)));
  assign out_load = rd_valid_r && (!out_valid_r || (out_tready && out_last));
  assign adv      = !rd_valid_r || out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
      cnt_r       <= '0;
    end else if (out_valid_r && out_tready) begin
      out_valid_r <= !out_last;
      cnt_r       <= cnt_r + OVS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      i_r <= i_nxt;
      q_r <= q_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last;
  assign out_tdata  = OUT_W'({q_r, i_r});

endmodule

>>> design/psm_checker.sv
// Port-level checker for the PSK symbol mapper, bound to the top level.
// Depends on psm_pkg and the assertion macros header.
`include "psk_symbol_mapper_upsampler_core_macros.svh"

module psm_checker import psm_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  localparam int OUT_W      = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic             out_tlast
);

  localparam logic [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  logic [SAMPLE_BITS-1:0] i_bits, q_bits;

  assign i_bits = out_tdata[SAMPLE_BITS-1:0];
  assign q_bits = out_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

  `PSM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled output transaction changed")
  `PSM_ASSERT_NEXT(a_repeat_run, out_tvalid && out_tready && !out_tlast, out_tvalid && $stable(out_tdata), "repeated copies of a sample broke up")
  `PSM_ASSERT_NOW(a_saturated, out_tvalid, i_bits != MOST_NEG && q_bits != MOST_NEG, "sample outside symmetric range")
  `PSM_ASSERT_NOW(a_stall_cause, in_tvalid && !in_tready, out_tvalid, "input stalled with an empty output")

endmodule

bind psk_symbol_mapper_upsampler_core psm_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_psm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
